// ===== rtl/ble_pkg.sv =====
// Shared types and constants for the bounded list engine.
`default_nettype none

package ble_pkg;

    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [2:0] {
        ACT_INS_HEAD = 3'd0,
        ACT_INS_TAIL = 3'd1,
        ACT_DEL_HEAD = 3'd2,
        ACT_DEL_TAIL = 3'd3,
        ACT_DEL_POS  = 3'd4,
        ACT_SEARCH   = 3'd5,
        ACT_SORT     = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD = 3'd0,
        OP_SHR  = 3'd1,
        OP_LOAD = 3'd2,
        OP_SHL  = 3'd3,
        OP_SORT = 3'd4,
        OP_SCAN = 3'd5
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;
        logic     first;
        logic     search;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bounded_list_engine_top.sv =====
// Top level of the bounded list engine: action sequencer and the row of list cells.
`default_nettype none

// The list lives in a row of DEPTH cells, entry 1 in cell 0, and every action is
// broadcast to all cells at once. One word is taken at a time and one result word
// is returned for it; a new word is taken while an earlier result still waits on
// the output. An insert shifts or loads the word in S_APPLY and then reports in S_FIN.
// Deletes and searches first drain a match through the cell row toward the head, one
// cell per cycle, over all N entries, where N is the entry count; a delete then shifts
// the row in S_APPLY. A sort runs N odd-even transposition passes, one per cycle.
// Actions that fail at once (full, empty, bad position) and the unused action code go
// straight to S_FIN. Entries are not cleared at reset; only the entry count is.
module bounded_list_engine_top #(
    parameter int DEPTH = ble_pkg::DEPTH_DEFAULT
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [2:0]  s_action,
    input  wire  [31:0] s_value,
    input  wire  [4:0]  s_position,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_removed_value,
    output logic [4:0]  m_found_position,
    output logic [4:0]  m_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 5) ? CW : 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_SORT,
        S_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        act_reg, act_next;
    logic [31:0]       val_reg, val_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     steps_reg, steps_next;
    logic              phase_reg, phase_next;
    logic              first_reg, first_next;
    logic              search_reg, search_next;
    ble_pkg::status_t  stat_reg, stat_next;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [31:0]       removed_reg, removed_next;
    logic [4:0]        found_reg, found_next;
    logic [4:0]        count_reg, count_next;

    ble_pkg::cell_cmd_t cmd;
    logic               is_delete;

    logic [31:0]   cell_data [DEPTH];
    logic          cell_swap [DEPTH];
    logic          pipe_hit  [DEPTH];
    logic [31:0]   pipe_val  [DEPTH];
    logic [CW-1:0] pipe_pos  [DEPTH];

    assign s_ready   = (state_reg == S_IDLE);
    assign is_delete = (act_reg == ble_pkg::ACT_DEL_HEAD) || (act_reg == ble_pkg::ACT_DEL_TAIL)
                       || (act_reg == ble_pkg::ACT_DEL_POS);

    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        val_next     = val_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        steps_next   = steps_reg;
        phase_next   = phase_reg;
        first_next   = first_reg;
        search_next  = search_reg;
        stat_next    = stat_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        removed_next = removed_reg;
        found_next   = found_reg;
        count_next   = count_reg;
        cmd.op       = ble_pkg::OP_HOLD;
        cmd.phase    = phase_reg;
        cmd.first    = first_reg;
        cmd.search   = search_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act_next    = s_action;
                    val_next    = s_value;
                    steps_next  = cnt_reg;
                    first_next  = 1'b1;
                    phase_next  = 1'b0;
                    search_next = 1'b0;
                    stat_next   = ble_pkg::STAT_OK;
                    state_next  = S_FIN;
                    case (s_action)
                        ble_pkg::ACT_INS_HEAD, ble_pkg::ACT_INS_TAIL: begin
                            if (cnt_reg == CW'(DEPTH)) begin
                                stat_next = ble_pkg::STAT_FULL;
                            end else begin
                                state_next = S_APPLY;
                            end
                        end
                        ble_pkg::ACT_DEL_HEAD, ble_pkg::ACT_DEL_TAIL: begin
                            if (cnt_reg == '0) begin
                                stat_next = ble_pkg::STAT_EMPTY;
                            end else begin
                                state_next = S_SCAN;
                                idx_next   = (s_action == ble_pkg::ACT_DEL_HEAD) ? '0
                                             : cnt_reg - CW'(1);
                            end
                        end
                        ble_pkg::ACT_DEL_POS: begin
                            if ((s_position == 5'd0) || (PW'(s_position) > PW'(cnt_reg))) begin
                                stat_next = ble_pkg::STAT_EMPTY;
                            end else begin
                                state_next = S_SCAN;
                                idx_next   = CW'(s_position - 5'd1);
                            end
                        end
                        ble_pkg::ACT_SEARCH: begin
                            if (cnt_reg == '0) begin
                                stat_next = ble_pkg::STAT_EMPTY;
                            end else begin
                                state_next  = S_SCAN;
                                search_next = 1'b1;
                            end
                        end
                        ble_pkg::ACT_SORT: begin
                            if (cnt_reg == '0) begin
                                stat_next = ble_pkg::STAT_EMPTY;
                            end else begin
                                state_next = S_SORT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                cmd.op     = ble_pkg::OP_SCAN;
                first_next = 1'b0;
                steps_next = steps_reg - CW'(1);
                if (steps_reg == CW'(1)) begin
                    state_next = search_reg ? S_FIN : S_APPLY;
                end
            end
            S_APPLY: begin
                state_next = S_FIN;
                case (act_reg)
                    ble_pkg::ACT_INS_HEAD: begin
                        cmd.op   = ble_pkg::OP_SHR;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    ble_pkg::ACT_INS_TAIL: begin
                        cmd.op   = ble_pkg::OP_LOAD;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    ble_pkg::ACT_DEL_HEAD, ble_pkg::ACT_DEL_TAIL, ble_pkg::ACT_DEL_POS: begin
                        cmd.op   = ble_pkg::OP_SHL;
                        cnt_next = cnt_reg - CW'(1);
                    end
                    default: begin
                    end
                endcase
            end
            S_SORT: begin
                cmd.op     = ble_pkg::OP_SORT;
                phase_next = ~phase_reg;
                steps_next = steps_reg - CW'(1);
                if (steps_reg == CW'(1)) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    status_next  = stat_reg;
                    removed_next = '0;
                    found_next   = '0;
                    count_next   = 5'(cnt_reg);
                    if (stat_reg == ble_pkg::STAT_OK) begin
                        if (search_reg) begin
                            if (pipe_hit[0]) begin
                                found_next = 5'(pipe_pos[0]);
                            end else begin
                                status_next = ble_pkg::STAT_NOTFOUND;
                            end
                        end else if (is_delete) begin
                            removed_next = pipe_val[0];
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg     <= act_next;
        val_reg     <= val_next;
        idx_reg     <= idx_next;
        steps_reg   <= steps_next;
        phase_reg   <= phase_next;
        first_reg   <= first_next;
        search_reg  <= search_next;
        stat_reg    <= stat_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        found_reg   <= found_next;
        count_reg   <= count_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [31:0]   left_d;
            logic [31:0]   right_d;
            logic          swap_i;
            logic          hit_i;
            logic [31:0]   val_i;
            logic [CW-1:0] pos_i;

            if (gi == 0) begin : g_head
                assign left_d = val_reg;
                assign swap_i = 1'b0;
            end else begin : g_mid
                assign left_d = cell_data[gi-1];
                assign swap_i = cell_swap[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign right_d = '0;
                assign hit_i   = 1'b0;
                assign val_i   = '0;
                assign pos_i   = '0;
            end else begin : g_body
                assign right_d = cell_data[gi+1];
                assign hit_i   = pipe_hit[gi+1];
                assign val_i   = pipe_val[gi+1];
                assign pos_i   = pipe_pos[gi+1];
            end

            ble_cell #(
                .DEPTH (DEPTH),
                .INDEX (gi)
            ) u_cell (
                .aclk        (aclk),
                .cmd         (cmd),
                .cmd_value   (val_reg),
                .sel_idx     (idx_reg),
                .count       (cnt_reg),
                .left_data   (left_d),
                .right_data  (right_d),
                .swap_in     (swap_i),
                .swap_out    (cell_swap[gi]),
                .data        (cell_data[gi]),
                .pipe_hit_in (hit_i),
                .pipe_val_in (val_i),
                .pipe_pos_in (pos_i),
                .pipe_hit    (pipe_hit[gi]),
                .pipe_val    (pipe_val[gi]),
                .pipe_pos    (pipe_pos[gi])
            );
        end
    endgenerate

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_removed_value  = removed_reg;
    assign m_found_position = found_reg;
    assign m_entry_count    = count_reg;

endmodule

`default_nettype wire

// ===== rtl/ble_cell.sv =====
// One storage cell of the list: holds one entry, shifts, swaps and scans with its neighbors.
`default_nettype none

module ble_cell #(
    parameter int DEPTH = ble_pkg::DEPTH_DEFAULT,
    parameter int INDEX = 0,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire                  aclk,
    input  ble_pkg::cell_cmd_t   cmd,
    input  wire  [31:0]          cmd_value,
    input  wire  [CW-1:0]        sel_idx,
    input  wire  [CW-1:0]        count,
    input  wire  [31:0]          left_data,
    input  wire  [31:0]          right_data,
    input  wire                  swap_in,
    output logic                 swap_out,
    output logic [31:0]          data,
    input  wire                  pipe_hit_in,
    input  wire  [31:0]          pipe_val_in,
    input  wire  [CW-1:0]        pipe_pos_in,
    output logic                 pipe_hit,
    output logic [31:0]          pipe_val,
    output logic [CW-1:0]        pipe_pos
);

    localparam logic [CW-1:0] MY_IDX = CW'(INDEX);
    localparam logic [CW-1:0] MY_POS = CW'(INDEX + 1);
    localparam logic          PARITY = 1'(INDEX % 2);

    logic [31:0]   data_reg, data_next;
    logic          hit_reg, hit_next;
    logic [31:0]   val_reg, val_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          hit;

    assign swap_out = (cmd.op == ble_pkg::OP_SORT) && (cmd.phase == PARITY)
                      && (MY_POS < count) && ($signed(data_reg) > $signed(right_data));

    assign hit = cmd.search ? ((MY_IDX < count) && (data_reg == cmd_value))
                            : (MY_IDX == sel_idx);

    always_comb begin
        data_next = data_reg;
        hit_next  = hit_reg;
        val_next  = val_reg;
        pos_next  = pos_reg;
        case (cmd.op)
            ble_pkg::OP_HOLD: begin
            end
            ble_pkg::OP_SHR: begin
                data_next = left_data;
            end
            ble_pkg::OP_LOAD: begin
                if (MY_IDX == count) begin
                    data_next = cmd_value;
                end
            end
            ble_pkg::OP_SHL: begin
                if (MY_IDX >= sel_idx) begin
                    data_next = right_data;
                end
            end
            ble_pkg::OP_SORT: begin
                if (swap_out) begin
                    data_next = right_data;
                end else if (swap_in) begin
                    data_next = left_data;
                end
            end
            ble_pkg::OP_SCAN: begin
                if (hit) begin
                    hit_next = 1'b1;
                    val_next = data_reg;
                    pos_next = MY_POS;
                end else if (cmd.first) begin
                    hit_next = 1'b0;
                    val_next = '0;
                    pos_next = '0;
                end else begin
                    hit_next = pipe_hit_in;
                    val_next = pipe_val_in;
                    pos_next = pipe_pos_in;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
        val_reg  <= val_next;
        pos_reg  <= pos_next;
    end

    assign data     = data_reg;
    assign pipe_hit = hit_reg;
    assign pipe_val = val_reg;
    assign pipe_pos = pos_reg;

endmodule

`default_nettype wire

// ===== rtl/ble_checker.sv =====
// Port-level assertions for the bounded list engine and their binding to the top level.
`default_nettype none

module ble_checker #(
    parameter int DEPTH = ble_pkg::DEPTH_DEFAULT
) (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire [1:0]  m_status,
    input wire [31:0] m_removed_value,
    input wire [4:0]  m_found_position,
    input wire [4:0]  m_entry_count
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_removed_value)
            && $stable(m_found_position) && $stable(m_entry_count))
        else $error("Result word changed while stalled.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("A second word was taken before the first one finished.");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_found_position != 5'd0) |->
            (m_status == ble_pkg::STAT_OK) && (m_removed_value == 32'd0))
        else $error("Found position reported without a successful search.");

    a_removed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_removed_value != 32'd0) |-> (m_status == ble_pkg::STAT_OK))
        else $error("Removed word reported on a failed action.");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ble_pkg::STAT_FULL) |-> (m_entry_count == 5'(DEPTH)))
        else $error("Full status reported with a list that is not full.");

endmodule

bind bounded_list_engine_top ble_checker #(.DEPTH(DEPTH)) u_ble_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_removed_value  (m_removed_value),
    .m_found_position (m_found_position),
    .m_entry_count    (m_entry_count)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the bounded list engine with a built-in list predictor.
`timescale 1ns / 100ps

module testbench;

    localparam int LIST_DEPTH = ble_pkg::DEPTH_DEFAULT;
    localparam logic [2:0] ACT_NOP = 3'd7;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 10;
    localparam int PRESSURE_HOLD = 300;

    typedef struct {
        ble_pkg::status_t status;
        logic [31:0]      removed;
        logic [4:0]       found;
        logic [4:0]       count;
    } list_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action = '0;
    logic [31:0] s_value = '0;
    logic [4:0]  s_position = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_removed_value;
    logic [4:0]  m_found_position;
    logic [4:0]  m_entry_count;

    logic [31:0]  shadow_entries [LIST_DEPTH];
    int           shadow_len = 0;
    list_result_t pending_results [$];
    int           mismatch_count = 0;
    int           quiet_cycles = 0;
    int           hold_off_len = 0;
    bit           src_idle = 1'b1;
    bit           sink_idle = 1'b1;

    bounded_list_engine_top #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_value(s_value),
        .s_position(s_position),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_removed_value(m_removed_value),
        .m_found_position(m_found_position),
        .m_entry_count(m_entry_count)
    );

    always #6 aclk = ~aclk;

    function automatic logic [31:0] take_entry(int idx);
        logic [31:0] word;
        word = shadow_entries[idx];
        for (int i = idx; i + 1 < shadow_len; i++) begin
            shadow_entries[i] = shadow_entries[i + 1];
        end
        shadow_len--;
        return word;
    endfunction

    function automatic list_result_t apply_action(logic [2:0] act, logic [31:0] val,
                                                  logic [4:0] pos);
        list_result_t r;
        logic [31:0]  t;
        bit           swapped;
        int           lim;
        r.status = ble_pkg::STAT_OK;
        r.removed = '0;
        r.found = '0;
        case (act)
            ble_pkg::ACT_INS_HEAD: begin
                if (shadow_len >= LIST_DEPTH) begin
                    r.status = ble_pkg::STAT_FULL;
                end else begin
                    for (int i = shadow_len; i > 0; i--) begin
                        shadow_entries[i] = shadow_entries[i - 1];
                    end
                    shadow_entries[0] = val;
                    shadow_len++;
                end
            end
            ble_pkg::ACT_INS_TAIL: begin
                if (shadow_len >= LIST_DEPTH) begin
                    r.status = ble_pkg::STAT_FULL;
                end else begin
                    shadow_entries[shadow_len] = val;
                    shadow_len++;
                end
            end
            ble_pkg::ACT_DEL_HEAD: begin
                if (shadow_len == 0) r.status = ble_pkg::STAT_EMPTY;
                else r.removed = take_entry(0);
            end
            ble_pkg::ACT_DEL_TAIL: begin
                if (shadow_len == 0) r.status = ble_pkg::STAT_EMPTY;
                else r.removed = take_entry(shadow_len - 1);
            end
            ble_pkg::ACT_DEL_POS: begin
                if (pos == 0 || pos > shadow_len) r.status = ble_pkg::STAT_EMPTY;
                else r.removed = take_entry(pos - 1);
            end
            ble_pkg::ACT_SEARCH: begin
                if (shadow_len == 0) begin
                    r.status = ble_pkg::STAT_EMPTY;
                end else begin
                    r.status = ble_pkg::STAT_NOTFOUND;
                    for (int i = 0; i < shadow_len; i++) begin
                        if (r.status == ble_pkg::STAT_NOTFOUND && shadow_entries[i] == val) begin
                            r.status = ble_pkg::STAT_OK;
                            r.found = 5'(i + 1);
                        end
                    end
                end
            end
            ble_pkg::ACT_SORT: begin
                if (shadow_len == 0) begin
                    r.status = ble_pkg::STAT_EMPTY;
                end else begin
                    lim = shadow_len;
                    swapped = 1'b1;
                    while (swapped && lim > 1) begin
                        swapped = 1'b0;
                        for (int i = 0; i + 1 < lim; i++) begin
                            if ($signed(shadow_entries[i]) > $signed(shadow_entries[i + 1])) begin
                                t = shadow_entries[i];
                                shadow_entries[i] = shadow_entries[i + 1];
                                shadow_entries[i + 1] = t;
                                swapped = 1'b1;
                            end
                        end
                        lim--;
                    end
                end
            end
            default: begin
            end
        endcase
        r.count = 5'(shadow_len);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_word(input logic [2:0] act, input logic [31:0] val,
                             input logic [4:0] pos);
        int gap;
        gap = src_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_value <= val;
        s_position <= pos;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(apply_action(act, val, pos));
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3, 4: return 32'($signed($urandom_range(0, 7)) - 4);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge aclk) begin : result_check
        list_result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word, status", 32'(m_status), '0);
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", 32'(m_status), 32'(want.status));
                if (m_removed_value !== want.removed)
                    report_mismatch("removed value", m_removed_value, want.removed);
                if (m_found_position !== want.found)
                    report_mismatch("found position", 32'(m_found_position), 32'(want.found));
                if (m_entry_count !== want.count)
                    report_mismatch("entry count", 32'(m_entry_count), 32'(want.count));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = hold_off_len + (sink_idle ? $urandom_range(0, 14) : 0);
            hold_off_len = 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    task automatic test_empty_list();
        send_word(ble_pkg::ACT_DEL_HEAD, 32'h0, 5'd1);
        send_word(ble_pkg::ACT_DEL_TAIL, 32'h0, 5'd1);
        send_word(ble_pkg::ACT_DEL_POS, 32'h0, 5'd1);
        send_word(ble_pkg::ACT_SEARCH, 32'h0, 5'd0);
        send_word(ble_pkg::ACT_SORT, 32'h0, 5'd0);
        send_word(ACT_NOP, 32'hFFFF_FFFF, 5'd31);
        send_word(ble_pkg::ACT_INS_TAIL, 32'h1234_5678, 5'd0);
        send_word(ble_pkg::ACT_DEL_POS, 32'h0, 5'd1);
    endtask

    task automatic test_full_list();
        logic [31:0] val;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            case (i % 5)
                0: val = 32'h8000_0000;
                1: val = 32'h7FFF_FFFF;
                2: val = 32'hFFFF_FFFF;
                3: val = 32'h0;
                default: val = $urandom;
            endcase
            send_word((i % 2) ? ble_pkg::ACT_INS_TAIL : ble_pkg::ACT_INS_HEAD, val, 5'(i));
        end
        send_word(ble_pkg::ACT_INS_HEAD, 32'h5555_5555, 5'd0);
        send_word(ble_pkg::ACT_INS_TAIL, 32'hAAAA_AAAA, 5'd0);
        send_word(ble_pkg::ACT_SEARCH, 32'h7FFF_FFFF, 5'd0);
        send_word(ble_pkg::ACT_SEARCH, 32'h1357_9BDF, 5'd0);
        send_word(ble_pkg::ACT_SORT, 32'h0, 5'd0);
        send_word(ble_pkg::ACT_DEL_POS, 32'h0, 5'd0);
        send_word(ble_pkg::ACT_DEL_POS, 32'h0, 5'd17);
        send_word(ble_pkg::ACT_DEL_POS, 32'h0, 5'd16);
        send_word(ble_pkg::ACT_DEL_HEAD, 32'h0, 5'd0);
        send_word(ble_pkg::ACT_DEL_TAIL, 32'h0, 5'd0);
    endtask

    task automatic send_random_word(input int grow);
        int          r;
        logic [2:0]  act;
        logic [31:0] val;
        logic [4:0]  pos;
        r = $urandom_range(0, 99);
        val = pick_value();
        pos = 5'($urandom_range(0, 31));
        if (r < grow) begin
            act = $urandom_range(0, 1) ? ble_pkg::ACT_INS_TAIL : ble_pkg::ACT_INS_HEAD;
        end else if (r < 75) begin
            case ($urandom_range(0, 2))
                0: act = ble_pkg::ACT_DEL_HEAD;
                1: act = ble_pkg::ACT_DEL_TAIL;
                default: begin
                    act = ble_pkg::ACT_DEL_POS;
                    if ($urandom_range(0, 99) < 85)
                        pos = 5'($urandom_range(1, shadow_len > 0 ? shadow_len : 1));
                end
            endcase
        end else if (r < 90) begin
            act = ble_pkg::ACT_SEARCH;
            if (shadow_len > 0 && $urandom_range(0, 99) < 65)
                val = shadow_entries[$urandom_range(0, shadow_len - 1)];
        end else if (r < 96) begin
            act = ble_pkg::ACT_SORT;
        end else begin
            act = $urandom_range(0, 1) ? ACT_NOP : ble_pkg::ACT_DEL_POS;
        end
        send_word(act, val, pos);
    endtask

    task automatic test_random_mix();
        int grow;
        for (int seg = 0; seg < 8; seg++) begin
            src_idle = (seg % 4) != 3;
            sink_idle = (seg % 4) != 2;
            case (seg % 3)
                0: grow = 55;
                1: grow = 25;
                default: grow = 40;
            endcase
            repeat (200) send_random_word(grow);
        end
        src_idle = 1'b1;
        sink_idle = 1'b1;
    endtask

    task automatic test_output_backpressure();
        src_idle = 1'b0;
        hold_off_len = PRESSURE_HOLD;
        for (int i = 0; i < 40; i++) begin
            send_random_word(45);
        end
        src_idle = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_list();
        test_full_list();
        test_output_backpressure();
        test_random_mix();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
